FILE: design/kabf_pkg.sv
`default_nettype none
package kabf_pkg;
	localparam logic CMD_STEP = 1'b0;
	localparam logic CMD_SEED = 1'b1;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 31;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ANGLE_NOISE = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_BIAS_NOISE = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MEAS_NOISE = 2'd2;

	localparam logic [CFG_DATA_BITS-1:0] ANGLE_NOISE_RESET = 31'd16777;
	localparam logic [CFG_DATA_BITS-1:0] BIAS_NOISE_RESET = 31'd83886;
	localparam logic [CFG_DATA_BITS-1:0] MEAS_NOISE_RESET = 31'd503316;

	// Datapath micro-operations.
	localparam int OP_BITS = 3;
	localparam logic [OP_BITS-1:0] OP_NOP = 3'd0;
	localparam logic [OP_BITS-1:0] OP_ADD = 3'd1;
	localparam logic [OP_BITS-1:0] OP_SUB = 3'd2;
	localparam logic [OP_BITS-1:0] OP_MUL = 3'd3;
	localparam logic [OP_BITS-1:0] OP_DIV = 3'd4;
	localparam logic [OP_BITS-1:0] OP_TERM = 3'd5;
	localparam logic [OP_BITS-1:0] OP_SEED = 3'd6;

	// Register file addresses.
	localparam int RA_BITS = 4;
	localparam logic [RA_BITS-1:0] R_ANG = 4'd0;
	localparam logic [RA_BITS-1:0] R_BIAS = 4'd1;
	localparam logic [RA_BITS-1:0] R_P00 = 4'd2;
	localparam logic [RA_BITS-1:0] R_P01 = 4'd3;
	localparam logic [RA_BITS-1:0] R_P10 = 4'd4;
	localparam logic [RA_BITS-1:0] R_P11 = 4'd5;
	localparam logic [RA_BITS-1:0] R_DT = 4'd6;
	localparam logic [RA_BITS-1:0] R_RATE = 4'd7;
	localparam logic [RA_BITS-1:0] R_MEAS = 4'd8;
	localparam logic [RA_BITS-1:0] R_QA = 4'd9;
	localparam logic [RA_BITS-1:0] R_QB = 4'd10;
	localparam logic [RA_BITS-1:0] R_RM = 4'd11;
	localparam logic [RA_BITS-1:0] R_T0 = 4'd12;
	localparam logic [RA_BITS-1:0] R_T1 = 4'd13;
	localparam logic [RA_BITS-1:0] R_T2 = 4'd14;
	localparam logic [RA_BITS-1:0] R_T3 = 4'd15;

	typedef struct packed {
		logic load;
		logic start;
		logic [OP_BITS-1:0] op;
		logic [RA_BITS-1:0] src_a;
		logic [RA_BITS-1:0] src_b;
		logic [RA_BITS-1:0] dst;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_status_t;
endpackage
`default_nettype wire

FILE: design/kabf_if.sv
`default_nettype none
interface kabf_in_if #(parameter int WORD_BITS = 32, parameter int FRAC_BITS = 24);
	logic valid;
	logic ready;
	logic command;
	logic signed [WORD_BITS-1:0] rate_sample;
	logic signed [WORD_BITS-1:0] tilt_sample;
	logic [FRAC_BITS-1:0] time_step;
	modport source(output valid, command, rate_sample, tilt_sample, time_step, input ready);
	modport sink(input valid, command, rate_sample, tilt_sample, time_step, output ready);
endinterface

interface kabf_out_if #(parameter int WORD_BITS = 32);
	logic valid;
	logic ready;
	logic signed [WORD_BITS-1:0] angle_estimate;
	logic signed [WORD_BITS-1:0] bias_estimate;
	modport source(output valid, angle_estimate, bias_estimate, input ready);
	modport sink(input valid, angle_estimate, bias_estimate, output ready);
endinterface
`default_nettype wire

FILE: design/kabf_datapath.sv
`default_nettype none
module kabf_datapath #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire kabf_pkg::dp_cmd_t cmd,
	output kabf_pkg::dp_status_t status,
	input wire logic command,
	input wire logic signed [WORD_BITS-1:0] rate_sample,
	input wire logic signed [WORD_BITS-1:0] tilt_sample,
	input wire logic [FRAC_BITS-1:0] time_step,
	input wire logic [kabf_pkg::CFG_DATA_BITS-1:0] angle_noise,
	input wire logic [kabf_pkg::CFG_DATA_BITS-1:0] bias_noise,
	input wire logic [kabf_pkg::CFG_DATA_BITS-1:0] meas_noise,
	output logic signed [WORD_BITS-1:0] angle_value,
	output logic signed [WORD_BITS-1:0] bias_value
);
	localparam int W = WORD_BITS;
	localparam int PW = 2 * W;
	// Dividend is |a| << FRAC_BITS; quotient width matches.
	localparam int NW = W + FRAC_BITS;
	localparam int CW = $clog2(NW + 2);
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam int CFGW = kabf_pkg::CFG_DATA_BITS;

	logic signed [W-1:0] rf_q [16];
	logic signed [W-1:0] a_q, b_q;
	logic [kabf_pkg::RA_BITS-1:0] dst_q;
	logic [kabf_pkg::OP_BITS-1:0] op_q;
	logic busy_q;
	logic [CW-1:0] cnt_q;
	logic neg_q;
	logic [PW-1:0] prod_s1;
	logic prod_v_s1;
	logic [NW-1:0] num_q;
	logic [W:0] rem_q;
	logic [W-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic done_q;

	function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] x);
		if (x > $signed({{2{WMAX[W-1]}}, WMAX})) return WMAX;
		if (x < $signed({{2{WMIN[W-1]}}, WMIN})) return WMIN;
		return x[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] reg_w(input logic [CFGW-1:0] v);
		logic [CFGW:0] e;
		logic [CFGW:0] m;
		e = {1'b0, v};
		m = (CFGW + 1)'((W >= CFGW + 1) ? {(CFGW + 1){1'b1}} : WMAX);
		if (W >= CFGW + 1) return W'(e);
		if (e > m) return WMAX;
		return W'(e);
	endfunction

	function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] x);
		return x[W-1] ? W'(-x) : W'(x);
	endfunction

	function automatic logic signed [W-1:0] from_mag(input logic neg, input logic [PW:0] m);
		if (neg) begin
			if (m >= (PW + 1)'({1'b0, WMAX}) + 1'b1) return WMIN;
			return W'(-m[W-1:0]);
		end
		if (m > (PW + 1)'({1'b0, WMAX})) return WMAX;
		return m[W-1:0];
	endfunction

	logic signed [W+1:0] a_x, b_x;
	logic signed [W+1:0] term_x;
	logic [W-1:0] ma, mb;
	logic [W:0] rem_sh;
	logic [PW:0] prod_rnd;
	logic [NW:0] quo_rnd;
	logic signed [W-1:0] rslt;
	logic wr;

	assign a_x = {{2{a_q[W-1]}}, a_q};
	assign b_x = {{2{b_q[W-1]}}, b_q};
	// Bracketed angle-variance term: A - P01 - P10 + QA (A is operand a), summed once.
	assign term_x = a_x - {{2{rf_q[kabf_pkg::R_P01][W-1]}}, rf_q[kabf_pkg::R_P01]}
		- {{2{rf_q[kabf_pkg::R_P10][W-1]}}, rf_q[kabf_pkg::R_P10]}
		+ {{2{rf_q[kabf_pkg::R_QA][W-1]}}, rf_q[kabf_pkg::R_QA]};
	assign ma = mag_w(a_q);
	assign mb = mag_w(b_q);
	assign rem_sh = {rem_q[W-1:0], num_q[NW-1]};
	assign prod_rnd = (PW + 1)'(({1'b0, prod_s1} + (PW + 1)'({1'b1, {(FRAC_BITS-1){1'b0}}}))
		>> FRAC_BITS);
	assign quo_rnd = {1'b0, quo_q}
		+ (NW + 1)'(({1'b0, rem_q} >= {1'b0, {1'b0, den_q}} - {1'b0, rem_q}) ? 1 : 0);

	always_comb begin
		rslt = '0;
		wr = 1'b0;
		case (op_q)
			kabf_pkg::OP_ADD: begin rslt = sat_w(a_x + b_x); wr = busy_q; end
			kabf_pkg::OP_SUB: begin rslt = sat_w(a_x - b_x); wr = busy_q; end
			kabf_pkg::OP_TERM: begin rslt = sat_w(term_x); wr = busy_q; end
			kabf_pkg::OP_MUL: begin rslt = from_mag(neg_q, prod_rnd); wr = prod_v_s1; end
			kabf_pkg::OP_DIV: begin
				rslt = (den_q == '0) ? '0 : from_mag(neg_q, (PW + 1)'(quo_rnd));
				wr = busy_q && (cnt_q == '0);
			end
			default: begin rslt = '0; wr = 1'b0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			prod_v_s1 <= 1'b0;
			done_q <= 1'b0;
			op_q <= kabf_pkg::OP_NOP;
			cnt_q <= '0;
			for (int i = 0; i < 16; i++) rf_q[i] <= '0;
		end else begin
			done_q <= wr;
			prod_v_s1 <= !cmd.start && busy_q && (op_q == kabf_pkg::OP_MUL)
				&& (cnt_q != CW'(NW + 1));
			if (cmd.load) begin
				rf_q[kabf_pkg::R_DT] <= W'({1'b0, time_step});
				rf_q[kabf_pkg::R_RATE] <= rate_sample;
				rf_q[kabf_pkg::R_MEAS] <= tilt_sample;
				rf_q[kabf_pkg::R_QA] <= reg_w(angle_noise);
				rf_q[kabf_pkg::R_QB] <= reg_w(bias_noise);
				rf_q[kabf_pkg::R_RM] <= reg_w(meas_noise);
				if (command == kabf_pkg::CMD_SEED) begin
					rf_q[kabf_pkg::R_ANG] <= tilt_sample;
					rf_q[kabf_pkg::R_BIAS] <= rate_sample;
				end
			end
			if (cmd.start) begin
				a_q <= rf_q[cmd.src_a];
				b_q <= rf_q[cmd.src_b];
				dst_q <= cmd.dst;
				op_q <= cmd.op;
				busy_q <= 1'b1;
				cnt_q <= CW'(NW + 1);
			end else if (busy_q) begin
				case (op_q)
					kabf_pkg::OP_MUL: begin
						if (cnt_q == CW'(NW + 1)) begin
							prod_s1 <= PW'(ma) * PW'(mb);
							neg_q <= a_q[W-1] ^ b_q[W-1];
							cnt_q <= cnt_q - 1'b1;
						end else begin
							busy_q <= 1'b0;
						end
					end
					kabf_pkg::OP_DIV: begin
						// A load step first, then one quotient bit per cycle for all NW bits.
						if (cnt_q == CW'(NW + 1)) begin
							num_q <= {ma, {FRAC_BITS{1'b0}}};
							den_q <= mb;
							rem_q <= '0;
							quo_q <= '0;
							neg_q <= a_q[W-1] ^ b_q[W-1];
							cnt_q <= cnt_q - 1'b1;
						end else if (cnt_q != '0) begin
							num_q <= num_q << 1;
							if (rem_sh >= {1'b0, den_q}) begin
								rem_q <= rem_sh - {1'b0, den_q};
								quo_q <= {quo_q[NW-2:0], 1'b1};
							end else begin
								rem_q <= rem_sh;
								quo_q <= {quo_q[NW-2:0], 1'b0};
							end
							cnt_q <= cnt_q - 1'b1;
						end else begin
							busy_q <= 1'b0;
						end
					end
					default: busy_q <= 1'b0;
				endcase
			end
			if (wr) begin
				rf_q[dst_q] <= rslt;
			end
		end
	end

	assign status.done = done_q;
	assign angle_value = rf_q[kabf_pkg::R_ANG];
	assign bias_value = rf_q[kabf_pkg::R_BIAS];
endmodule
`default_nettype wire

FILE: design/kabf_ctrl.sv
`default_nettype none
module kabf_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic in_command,
	output logic out_valid,
	input wire logic out_ready,
	output kabf_pkg::dp_cmd_t cmd,
	input wire kabf_pkg::dp_status_t status
);
	localparam int SW = 2;
	localparam logic [SW-1:0] ST_IDLE = 2'd0;
	localparam logic [SW-1:0] ST_ISSUE = 2'd1;
	localparam logic [SW-1:0] ST_WAIT = 2'd2;
	localparam logic [SW-1:0] ST_OUT = 2'd3;
	localparam int NSTEP = 24;
	localparam int PCW = 5;

	logic [SW-1:0] state_q;
	logic [PCW-1:0] pc_q;
	kabf_pkg::dp_cmd_t uop;

	// Microprogram: one datapath operation per entry.
	always_comb begin
		uop = '0;
		case (pc_q)
			5'd0: uop = '{1'b0, 1'b1, kabf_pkg::OP_SUB, kabf_pkg::R_RATE, kabf_pkg::R_BIAS, kabf_pkg::R_T0};
			5'd1: uop = '{1'b0, 1'b1, kabf_pkg::OP_MUL, kabf_pkg::R_DT, kabf_pkg::R_T0, kabf_pkg::R_T0};
			5'd2: uop = '{1'b0, 1'b1, kabf_pkg::OP_ADD, kabf_pkg::R_ANG, kabf_pkg::R_T0, kabf_pkg::R_ANG};
			5'd3: uop = '{1'b0, 1'b1, kabf_pkg::OP_MUL, kabf_pkg::R_DT, kabf_pkg::R_P11, kabf_pkg::R_T1};
			5'd4: uop = '{1'b0, 1'b1, kabf_pkg::OP_TERM, kabf_pkg::R_T1, kabf_pkg::R_T1, kabf_pkg::R_T0};
			5'd5: uop = '{1'b0, 1'b1, kabf_pkg::OP_MUL, kabf_pkg::R_DT, kabf_pkg::R_T0, kabf_pkg::R_T0};
			5'd6: uop = '{1'b0, 1'b1, kabf_pkg::OP_ADD, kabf_pkg::R_P00, kabf_pkg::R_T0, kabf_pkg::R_P00};
			5'd7: uop = '{1'b0, 1'b1, kabf_pkg::OP_SUB, kabf_pkg::R_P01, kabf_pkg::R_T1, kabf_pkg::R_P01};
			5'd8: uop = '{1'b0, 1'b1, kabf_pkg::OP_SUB, kabf_pkg::R_P10, kabf_pkg::R_T1, kabf_pkg::R_P10};
			5'd9: uop = '{1'b0, 1'b1, kabf_pkg::OP_MUL, kabf_pkg::R_QB, kabf_pkg::R_DT, kabf_pkg::R_T0};
			5'd10: uop = '{1'b0, 1'b1, kabf_pkg::OP_ADD, kabf_pkg::R_P11, kabf_pkg::R_T0, kabf_pkg::R_P11};
			5'd11: uop = '{1'b0, 1'b1, kabf_pkg::OP_SUB, kabf_pkg::R_MEAS, kabf_pkg::R_ANG, kabf_pkg::R_T2};
			5'd12: uop = '{1'b0, 1'b1, kabf_pkg::OP_ADD, kabf_pkg::R_P00, kabf_pkg::R_RM, kabf_pkg::R_T3};
			5'd13: uop = '{1'b0, 1'b1, kabf_pkg::OP_DIV, kabf_pkg::R_P00, kabf_pkg::R_T3, kabf_pkg::R_T0};
			5'd14: uop = '{1'b0, 1'b1, kabf_pkg::OP_DIV, kabf_pkg::R_P10, kabf_pkg::R_T3, kabf_pkg::R_T1};
			5'd15: uop = '{1'b0, 1'b1, kabf_pkg::OP_MUL, kabf_pkg::R_T0, kabf_pkg::R_T2, kabf_pkg::R_T3};
			5'd16: uop = '{1'b0, 1'b1, kabf_pkg::OP_ADD, kabf_pkg::R_ANG, kabf_pkg::R_T3, kabf_pkg::R_ANG};
			5'd17: uop = '{1'b0, 1'b1, kabf_pkg::OP_MUL, kabf_pkg::R_T1, kabf_pkg::R_T2, kabf_pkg::R_T3};
			5'd18: uop = '{1'b0, 1'b1, kabf_pkg::OP_ADD, kabf_pkg::R_BIAS, kabf_pkg::R_T3, kabf_pkg::R_BIAS};
			5'd19: uop = '{1'b0, 1'b1, kabf_pkg::OP_MUL, kabf_pkg::R_T1, kabf_pkg::R_P00, kabf_pkg::R_T2};
			5'd20: uop = '{1'b0, 1'b1, kabf_pkg::OP_SUB, kabf_pkg::R_P10, kabf_pkg::R_T2, kabf_pkg::R_P10};
			5'd21: uop = '{1'b0, 1'b1, kabf_pkg::OP_MUL, kabf_pkg::R_T1, kabf_pkg::R_P01, kabf_pkg::R_T2};
			5'd22: uop = '{1'b0, 1'b1, kabf_pkg::OP_SUB, kabf_pkg::R_P11, kabf_pkg::R_T2, kabf_pkg::R_P11};
			5'd23: uop = '{1'b0, 1'b1, kabf_pkg::OP_MUL, kabf_pkg::R_T0, kabf_pkg::R_P00, kabf_pkg::R_T2};
			5'd24: uop = '{1'b0, 1'b1, kabf_pkg::OP_MUL, kabf_pkg::R_T0, kabf_pkg::R_P01, kabf_pkg::R_T3};
			5'd25: uop = '{1'b0, 1'b1, kabf_pkg::OP_SUB, kabf_pkg::R_P00, kabf_pkg::R_T2, kabf_pkg::R_P00};
			5'd26: uop = '{1'b0, 1'b1, kabf_pkg::OP_SUB, kabf_pkg::R_P01, kabf_pkg::R_T3, kabf_pkg::R_P01};
			default: uop = '0;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		if (state_q == ST_IDLE) begin
			cmd.load = in_valid;
		end else if (state_q == ST_ISSUE) begin
			cmd = uop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					pc_q <= '0;
					if (in_valid) begin
						state_q <= (in_command == kabf_pkg::CMD_SEED) ? ST_OUT : ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (status.done) begin
						if (pc_q == PCW'(NSTEP + 2)) begin
							state_q <= ST_OUT;
						end else begin
							pc_q <= pc_q + 1'b1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: design/kalman_angle_bias_filter_core.sv
// Kalman angle and gyro-bias filter, one axis.
// Input channel (in): command, rate_sample, tilt_sample, time_step. Command
// step runs predict and update; command seed loads angle and bias directly.
// Output channel (out): angle_estimate and bias_estimate, one per input.
// Configuration: write cfg_we with cfg_index 0..2 (angle noise, bias noise,
// measurement noise), only while the block is idle.
// One item at a time: a filter step is a 27-operation microprogram on one
// shared ALU, run one operation after another; each of the two divides
// produces one quotient bit per cycle. A seed shows its result in the next
// cycle. The result is held in the state registers and shown while
// out.valid is high; a stalled receiver holds the block, and the next
// transfer on in is taken only after the result transfer.
// Reset clears angle, bias and covariance and restores default noise values.
`default_nettype none
module kalman_angle_bias_filter_core #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	kabf_in_if.sink in,
	kabf_out_if.source out,
	input wire logic cfg_we,
	input wire logic [kabf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input wire logic [kabf_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	logic [kabf_pkg::CFG_DATA_BITS-1:0] qa_q, qb_q, rm_q;
	kabf_pkg::dp_cmd_t cmd;
	kabf_pkg::dp_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= kabf_pkg::ANGLE_NOISE_RESET;
			qb_q <= kabf_pkg::BIAS_NOISE_RESET;
			rm_q <= kabf_pkg::MEAS_NOISE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				kabf_pkg::CFG_ANGLE_NOISE: qa_q <= cfg_data;
				kabf_pkg::CFG_BIAS_NOISE: qb_q <= cfg_data;
				kabf_pkg::CFG_MEAS_NOISE: rm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	kabf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready), .in_command(in.command),
		.out_valid(out.valid), .out_ready(out.ready),
		.cmd(cmd), .status(status)
	);

	kabf_datapath #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.command(in.command), .rate_sample(in.rate_sample),
		.tilt_sample(in.tilt_sample), .time_step(in.time_step),
		.angle_noise(qa_q), .bias_noise(qb_q), .meas_noise(rm_q),
		.angle_value(out.angle_estimate), .bias_value(out.bias_estimate)
	);

`ifndef SYNTHESIS
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> !in.ready) else $error("input taken while result pending");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.angle_estimate))
		else $error("result changed while stalled");
	a_no_op_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in.ready |-> !cmd.start) else $error("operation issued while idle");
`endif
endmodule
`default_nettype wire
